/* sv/lrs_pkg.sv */
// ============================================================================
// lrs_pkg
// Shared types, widths, codes and the sigmoid table generator of the
// logistic regression scorer.
// ============================================================================
package lrs_pkg;

  // Field widths
  localparam int OP_W        = 2;
  localparam int INDEX_W     = 10;
  localparam int VALUE_W     = 16;
  localparam int PROD_W      = 2 * VALUE_W;
  localparam int PROB_W      = 17;
  localparam int COUNT_OUT_W = 32;

  // Index space of the feature_index field
  localparam int INDEX_SPAN = 2 ** INDEX_W;

  // Accumulator: Q18.24, one extra bit for the raw sum before saturation
  localparam int ACC_W = 42;
  localparam int SUM_W = ACC_W + 1;

  // Clamped sum: [-8,8) in Q.24 fits 28 bits signed
  localparam int CLAMP_W = 28;

  // Decision threshold after reset (Q1.16)
  localparam logic [PROB_W-1:0] THRESHOLD_RESET = PROB_W'(65470);

  // Queue between front and back
  localparam int QUEUE_DEPTH = 4;

  // Operation codes of a request
  typedef enum logic [OP_W-1:0] {
    OP_LOAD    = 2'd0,
    OP_FEATURE = 2'd1,
    OP_CLEAR   = 2'd2,
    OP_NONE    = 2'd3
  } op_t;

  // Kinds of work handed to the back end
  typedef enum logic {
    KIND_FEATURE = 1'b0,
    KIND_CLEAR   = 1'b1
  } item_kind_t;

  // One queued work item
  typedef struct packed {
    item_kind_t                 kind;
    logic signed [VALUE_W-1:0]  weight;
    logic signed [VALUE_W-1:0]  value;
    logic                       in_range;
    logic                       last;
    logic                       label;
  } q_item_t;

  // Restoring divider, used only while building constant tables
  function automatic logic [63:0] udiv64(input logic [63:0] num, input logic [63:0] den);
    logic [63:0] quo;
    logic [64:0] rem;
    quo = '0;
    rem = '0;
    for (int i = 63; i >= 0; i--) begin
      rem = {rem[63:0], num[i]};
      if (rem >= {1'b0, den}) begin
        rem    = rem - {1'b0, den};
        quo[i] = 1'b1;
      end
    end
    return quo;
  endfunction

  // Sigmoid table entry k of an n-entry table, Q1.16 rounded
  function automatic logic [PROB_W-1:0] sig_entry(input int k, input int n);
    int          d;
    logic [63:0] span;
    logic [63:0] y;
    logic [63:0] term;
    logic [63:0] acc;
    logic [63:0] e;
    logic [63:0] den;
    logic [63:0] num;
    d    = 2 * k + 1 - n;
    span = (d < 0) ? 64'(-d) : 64'(d);
    y    = udiv64(span << 29, 64'(n));
    term = 64'd1 << 30;
    acc  = term;
    // Taylor series of exp(y) through the twelfth power, in Q30
    for (int m = 1; m <= 12; m++) begin
      term = udiv64((term * y) >> 30, 64'(m));
      acc  = acc + term;
    end
    e = (acc + 64'd32) >> 6;
    // Raise to the 16th power
    for (int s = 0; s < 4; s++) begin
      e = (e * e + (64'd1 << 23)) >> 24;
    end
    den = e + (64'd1 << 24);
    num = (d >= 0) ? (e << 16) : (64'd1 << 40);
    return PROB_W'(udiv64(num + (den >> 1), den));
  endfunction

endpackage

/* sv/lrs_in_if.sv */
// ============================================================================
// lrs_in_if
// Request channel of the scorer: weight loads, feature elements, clears.
// ============================================================================
interface lrs_in_if
  import lrs_pkg::*;
;
  logic                       valid;
  logic                       ready;
  logic [OP_W-1:0]            operation;
  logic [INDEX_W-1:0]         feature_index;
  logic signed [VALUE_W-1:0]  element_value;
  logic                       last_element;
  logic                       observed_label;

  modport source (
    output valid, operation, feature_index, element_value, last_element, observed_label,
    input  ready
  );
  modport sink (
    input  valid, operation, feature_index, element_value, last_element, observed_label,
    output ready
  );
endinterface

/* sv/lrs_out_if.sv */
// ============================================================================
// lrs_out_if
// Result channel of the scorer: probability, class and confusion counters.
// ============================================================================
interface lrs_out_if
  import lrs_pkg::*;
;
  logic                    valid;
  logic                    ready;
  logic [PROB_W-1:0]       probability;
  logic                    predicted_class;
  logic [COUNT_OUT_W-1:0]  true_positives;
  logic [COUNT_OUT_W-1:0]  false_positives;
  logic [COUNT_OUT_W-1:0]  false_negatives;
  logic [COUNT_OUT_W-1:0]  true_negatives;

  modport source (
    output valid, probability, predicted_class, true_positives, false_positives,
           false_negatives, true_negatives,
    input  ready
  );
  modport sink (
    input  valid, probability, predicted_class, true_positives, false_positives,
           false_negatives, true_negatives,
    output ready
  );
endinterface

/* sv/lrs_cfg_if.sv */
// ============================================================================
// lrs_cfg_if
// Configuration write channel: the decision threshold.
// ============================================================================
interface lrs_cfg_if
  import lrs_pkg::*;
;
  logic               valid;
  logic               ready;
  logic [PROB_W-1:0]  decision_threshold;

  modport source (output valid, decision_threshold, input ready);
  modport sink (input valid, decision_threshold, output ready);
endinterface

/* sv/lrs_front.sv */
// ============================================================================
// lrs_front
// Accepts requests, decodes the operation, owns the weight memory and hands
// feature elements (with their weight) and clears to the queue.
// ============================================================================
module lrs_front
  import lrs_pkg::*;
#(
  parameter int FEATURE_COUNT = 1024
) (
  input  logic     clk,
  input  logic     rst_n,
  lrs_in_if.sink   in_chan,
  output q_item_t  push_item,
  output logic     push_valid,
  input  logic     push_ready
);

  localparam int DEPTH  = (FEATURE_COUNT < INDEX_SPAN) ? FEATURE_COUNT : INDEX_SPAN;
  localparam int ADDR_W = $clog2(DEPTH);

  logic signed [VALUE_W-1:0] weight_mem [DEPTH];
  logic signed [VALUE_W-1:0] weight_rd_r;

  logic        f_valid_r, f_valid_nxt;
  item_kind_t  f_kind_r;
  logic signed [VALUE_W-1:0] f_value_r;
  logic        f_in_range_r;
  logic        f_last_r;
  logic        f_label_r;

  logic              accept;
  logic              in_range;
  logic              forward;
  logic              is_load;
  logic              is_feature;
  logic [ADDR_W-1:0] addr;
  op_t               op;

  assign in_chan.ready = !f_valid_r || push_ready;
  assign accept        = in_chan.valid && in_chan.ready;
  assign in_range      = 32'(in_chan.feature_index) < 32'(DEPTH);
  assign addr          = in_chan.feature_index[ADDR_W-1:0];
  assign op            = op_t'(in_chan.operation);

  // Decode
  always_comb begin
    is_load    = 1'b0;
    is_feature = 1'b0;
    forward    = 1'b0;
    case (op)
      OP_LOAD:    is_load = 1'b1;
      OP_FEATURE: begin
        is_feature = 1'b1;
        forward    = 1'b1;
      end
      OP_CLEAR:   forward = 1'b1;
      default:    forward = 1'b0;
    endcase
  end

  // Stage slot: freed by a push, refilled by a forwarded request
  always_comb begin
    f_valid_nxt = f_valid_r && !push_ready;
    if (accept) f_valid_nxt = forward;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f_valid_r <= 1'b0;
    end else begin
      f_valid_r <= f_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      f_kind_r     <= is_feature ? KIND_FEATURE : KIND_CLEAR;
      f_value_r    <= in_chan.element_value;
      f_in_range_r <= in_range;
      f_last_r     <= in_chan.last_element;
      f_label_r    <= in_chan.observed_label;
    end
  end

  // Weight memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (accept && is_load && in_range) begin
      weight_mem[addr] <= in_chan.element_value;
    end
    if (accept && is_feature) begin
      weight_rd_r <= weight_mem[addr];
    end
  end

  assign push_valid         = f_valid_r;
  assign push_item.kind     = f_kind_r;
  assign push_item.weight   = weight_rd_r;
  assign push_item.value    = f_value_r;
  assign push_item.in_range = f_in_range_r;
  assign push_item.last     = f_last_r;
  assign push_item.label    = f_label_r;

endmodule

/* sv/lrs_queue.sv */
// ============================================================================
// lrs_queue
// Short FIFO between front and back so that each side stalls on its own.
// ============================================================================
module lrs_queue
  import lrs_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  q_item_t  push_item,
  input  logic     push_valid,
  output logic     push_ready,
  output q_item_t  pop_item,
  output logic     pop_valid,
  input  logic     pop_ready
);

  localparam int PTR_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  q_item_t            slots [QUEUE_DEPTH];
  logic [PTR_W-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0]   count_r, count_nxt;
  logic               do_push, do_pop;

  assign push_ready = count_r != CNT_W'(QUEUE_DEPTH);
  assign pop_valid  = count_r != '0;
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;
  assign pop_item   = slots[rd_ptr_r];

  // Pointer and fill bookkeeping
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) wr_ptr_nxt = (wr_ptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    if (do_pop)  rd_ptr_nxt = (rd_ptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    if (do_push && !do_pop) count_nxt = count_r + 1'b1;
    if (!do_push && do_pop) count_nxt = count_r - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) slots[wr_ptr_r] <= push_item;
  end

endmodule

/* sv/lrs_back.sv */
// ============================================================================
// lrs_back
// Multiply, accumulate, sigmoid lookup and confusion counting. Four stages
// plus an output register, all advancing together unless the result stalls.
// ============================================================================
module lrs_back
  import lrs_pkg::*;
#(
  parameter int SIGMOID_ENTRIES = 256,
  parameter int COUNTER_BITS    = 32
) (
  input  logic              clk,
  input  logic              rst_n,
  input  q_item_t           pop_item,
  input  logic              pop_valid,
  output logic              pop_ready,
  input  logic [PROB_W-1:0] threshold,
  lrs_out_if.source         out_chan
);

  localparam int POS_W   = $clog2(SIGMOID_ENTRIES);
  localparam int ENT_W   = $clog2(SIGMOID_ENTRIES + 1);
  localparam int SCALE_W = CLAMP_W + ENT_W;

  localparam logic signed [ACC_W-1:0]   ACC_MAX   = {1'b0, {(ACC_W - 1){1'b1}}};
  localparam logic signed [ACC_W-1:0]   ACC_MIN   = {1'b1, {(ACC_W - 1){1'b0}}};
  localparam logic signed [CLAMP_W-1:0] CLAMP_MAX = {1'b0, {(CLAMP_W - 1){1'b1}}};
  localparam logic signed [CLAMP_W-1:0] CLAMP_MIN = {1'b1, {(CLAMP_W - 1){1'b0}}};

  typedef logic [COUNTER_BITS-1:0] count_t;

  // Sigmoid table, built at elaboration
  logic [PROB_W-1:0] sig_rom [SIGMOID_ENTRIES];
  for (genvar g = 0; g < SIGMOID_ENTRIES; g++) begin : g_rom
    localparam logic [PROB_W-1:0] ENTRY = sig_entry(g, SIGMOID_ENTRIES);
    assign sig_rom[g] = ENTRY;
  end

  logic en;

  // Multiply stage
  logic                       m_valid_r;
  item_kind_t                 m_kind_r;
  logic                       m_last_r, m_label_r;
  logic signed [PROD_W-1:0]   m_prod_r;
  logic signed [PROD_W-1:0]   mul_prod;

  // Accumulate stage
  logic                       a_valid_r;
  item_kind_t                 a_kind_r;
  logic                       a_last_r, a_label_r;
  logic signed [ACC_W-1:0]    a_sum_r;
  logic signed [ACC_W-1:0]    acc_r;

  // Table index stage
  logic                       p_valid_r;
  item_kind_t                 p_kind_r;
  logic                       p_last_r, p_label_r;
  logic [POS_W-1:0]           p_pos_r;

  // Table read stage
  logic                       t_valid_r;
  item_kind_t                 t_kind_r;
  logic                       t_last_r, t_label_r;
  logic [PROB_W-1:0]          t_prob_r;

  // Counters and output register
  count_t tp_r, tp_nxt, fp_r, fp_nxt, fn_r, fn_nxt, tn_r, tn_nxt;
  logic                      out_valid_r;
  logic [PROB_W-1:0]         out_prob_r;
  logic                      out_pred_r;
  logic [COUNT_OUT_W-1:0]    out_tp_r, out_fp_r, out_fn_r, out_tn_r;

  logic signed [SUM_W-1:0]   sum_wide;
  logic signed [ACC_W-1:0]   sum_sat;
  logic signed [CLAMP_W-1:0] clamped;
  logic [CLAMP_W-1:0]        offset;
  logic [SCALE_W-1:0]        scaled;
  logic                      fits;
  logic                      pred;
  logic                      result;

  function automatic count_t bump(input count_t c);
    return (&c) ? c : c + COUNTER_BITS'(1);
  endfunction

  assign en        = !out_valid_r || out_chan.ready;
  assign pop_ready = en;

  // Multiply: Q4.12 x Q4.12 -> Q8.24, exact
  assign mul_prod = $signed(pop_item.weight) * $signed(pop_item.value);

  always_ff @(posedge clk) begin
    if (en && pop_valid) begin
      m_kind_r  <= pop_item.kind;
      m_last_r  <= pop_item.last;
      m_label_r <= pop_item.label;
      m_prod_r  <= pop_item.in_range ? mul_prod : '0;
    end
  end

  // Accumulate with saturation at the accumulator bounds
  always_comb begin
    sum_wide = SUM_W'(acc_r) + SUM_W'(m_prod_r);
    if (sum_wide[ACC_W] != sum_wide[ACC_W-1]) begin
      sum_sat = sum_wide[ACC_W] ? ACC_MIN : ACC_MAX;
    end else begin
      sum_sat = sum_wide[ACC_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r <= '0;
    end else if (en && m_valid_r && m_kind_r == KIND_FEATURE) begin
      acc_r <= m_last_r ? '0 : sum_sat;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a_kind_r  <= m_kind_r;
      a_last_r  <= m_last_r;
      a_label_r <= m_label_r;
      a_sum_r   <= sum_sat;
    end
  end

  // Clamp to [-8,8), shift to unsigned, scale to a table index
  always_comb begin
    fits = (&a_sum_r[ACC_W-1:CLAMP_W-1]) || !(|a_sum_r[ACC_W-1:CLAMP_W-1]);
    if (fits) begin
      clamped = a_sum_r[CLAMP_W-1:0];
    end else begin
      clamped = a_sum_r[ACC_W-1] ? CLAMP_MIN : CLAMP_MAX;
    end
    offset = {~clamped[CLAMP_W-1], clamped[CLAMP_W-2:0]};
    scaled = SCALE_W'(offset) * SCALE_W'(SIGMOID_ENTRIES);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p_kind_r  <= a_kind_r;
      p_last_r  <= a_last_r;
      p_label_r <= a_label_r;
      p_pos_r   <= scaled[CLAMP_W +: POS_W];
    end
  end

  // Table read
  always_ff @(posedge clk) begin
    if (en) begin
      t_kind_r  <= p_kind_r;
      t_last_r  <= p_last_r;
      t_label_r <= p_label_r;
      t_prob_r  <= sig_rom[p_pos_r];
    end
  end

  // Stage valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      m_valid_r <= 1'b0;
      a_valid_r <= 1'b0;
      p_valid_r <= 1'b0;
      t_valid_r <= 1'b0;
    end else if (en) begin
      m_valid_r <= pop_valid;
      a_valid_r <= m_valid_r;
      p_valid_r <= a_valid_r;
      t_valid_r <= p_valid_r;
    end
  end

  // Threshold compare and confusion counter update
  always_comb begin
    tp_nxt = tp_r;
    fp_nxt = fp_r;
    fn_nxt = fn_r;
    tn_nxt = tn_r;
    pred   = t_prob_r >= threshold;
    result = t_valid_r && t_kind_r == KIND_FEATURE && t_last_r;
    if (t_valid_r && t_kind_r == KIND_CLEAR) begin
      tp_nxt = '0;
      fp_nxt = '0;
      fn_nxt = '0;
      tn_nxt = '0;
    end else if (result) begin
      case ({t_label_r, pred})
        2'b11:   tp_nxt = bump(tp_r);
        2'b01:   fp_nxt = bump(fp_r);
        2'b10:   fn_nxt = bump(fn_r);
        default: tn_nxt = bump(tn_r);
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tp_r        <= '0;
      fp_r        <= '0;
      fn_r        <= '0;
      tn_r        <= '0;
      out_valid_r <= 1'b0;
    end else if (en) begin
      tp_r        <= tp_nxt;
      fp_r        <= fp_nxt;
      fn_r        <= fn_nxt;
      tn_r        <= tn_nxt;
      out_valid_r <= result;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (en && result) begin
      out_prob_r <= t_prob_r;
      out_pred_r <= pred;
      out_tp_r   <= COUNT_OUT_W'(tp_nxt);
      out_fp_r   <= COUNT_OUT_W'(fp_nxt);
      out_fn_r   <= COUNT_OUT_W'(fn_nxt);
      out_tn_r   <= COUNT_OUT_W'(tn_nxt);
    end
  end

  assign out_chan.valid           = out_valid_r;
  assign out_chan.probability     = out_prob_r;
  assign out_chan.predicted_class = out_pred_r;
  assign out_chan.true_positives  = out_tp_r;
  assign out_chan.false_positives = out_fp_r;
  assign out_chan.false_negatives = out_fn_r;
  assign out_chan.true_negatives  = out_tn_r;

endmodule

/* sv/logistic_regression_scorer.sv */
// ============================================================================
// logistic_regression_scorer
// Sparse logistic regression inference with saturating confusion counters.
//
// Usage:
//   in_chan  - requests: load a weight, stream a feature element, or clear
//              the confusion counters. One request per cycle unless stalled.
//   out_chan - one result per example, on the element marked last: the
//              Q1.16 probability, the predicted class and the four counters
//              after this example's update.
//   cfg_chan - writes the decision threshold; always ready. Write it only
//              while no example is in flight.
// Path: after its last element is accepted, a result passes the front stage,
//   the queue, multiply, accumulate, table index and table read stages, then
//   the output register, before it shows on out_chan.
// Throughput: one request per cycle while in_chan.ready is high; the weight
//   memory's single read port and one multiply-accumulate per cycle set it.
// Reset: counters and accumulator clear, threshold returns to 65470; the
//   weight memory keeps whatever it held and must be loaded before use.
// Stall: while out_chan is stalled the back end holds; the front keeps
//   taking requests until the 4-entry queue and the front stage slot both
//   hold a request, then in_chan.ready drops.
// ============================================================================
module logistic_regression_scorer
  import lrs_pkg::*;
#(
  parameter int FEATURE_COUNT   = 1024,
  parameter int SIGMOID_ENTRIES = 256,
  parameter int COUNTER_BITS    = 32
) (
  input  logic       clk,
  input  logic       rst_n,
  lrs_in_if.sink     in_chan,
  lrs_out_if.source  out_chan,
  lrs_cfg_if.sink    cfg_chan
);

  logic [PROB_W-1:0] threshold_r;

  q_item_t push_item, pop_item;
  logic    push_valid, push_ready;
  logic    pop_valid, pop_ready;

  // Threshold register
  assign cfg_chan.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      threshold_r <= THRESHOLD_RESET;
    end else if (cfg_chan.valid) begin
      threshold_r <= cfg_chan.decision_threshold;
    end
  end

  lrs_front #(
    .FEATURE_COUNT (FEATURE_COUNT)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_chan    (in_chan),
    .push_item  (push_item),
    .push_valid (push_valid),
    .push_ready (push_ready)
  );

  lrs_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_item  (push_item),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .pop_item   (pop_item),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready)
  );

  lrs_back #(
    .SIGMOID_ENTRIES (SIGMOID_ENTRIES),
    .COUNTER_BITS    (COUNTER_BITS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .pop_item  (pop_item),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .threshold (threshold_r),
    .out_chan  (out_chan)
  );

endmodule

/* sim/tb_logistic_regression_scorer.sv */
// ============================================================================
// tb_logistic_regression_scorer
// Self-checking bench for the logistic regression scorer. Loads weights,
// streams directed and random examples under a range of decision
// thresholds, and checks every score against an in-bench model of the
// scoring pipeline.
// ============================================================================
module tb_logistic_regression_scorer
  import lrs_pkg::*;
;
  timeunit 1ns;
  timeprecision 1ps;

  typedef longint unsigned u64_t;

  localparam int                FEATURES        = 1024;
  localparam int                SIG_N           = 256;
  localparam logic [PROB_W-1:0] RESET_THRESHOLD = 17'd65470;
  localparam longint            ACC_HI          = (longint'(1) <<< 41) - 1;
  localparam longint            ACC_LO          = -ACC_HI - 1;
  localparam longint            SUM_HI          = (longint'(1) <<< 27) - 1;
  localparam longint            SUM_LO          = -SUM_HI - 1;
  localparam u64_t              CNT_FULL        = (u64_t'(1) << 32) - 1;
  localparam int                SETTLE_CYCLES   = 12;
  localparam int                CYCLE_LIMIT     = 1_000_000;
  localparam int                PHASE_ITEMS     = 85;

  typedef struct {
    logic [PROB_W-1:0]      probability;
    logic                   predicted_class;
    logic [COUNT_OUT_W-1:0] true_positives;
    logic [COUNT_OUT_W-1:0] false_positives;
    logic [COUNT_OUT_W-1:0] false_negatives;
    logic [COUNT_OUT_W-1:0] true_negatives;
  } score_t;

  // --------------------------------------------------------------------------
  // Scoring model: weights, dot product, sigmoid table, confusion counters
  // --------------------------------------------------------------------------
  class confusion_scoreboard;
    logic [PROB_W-1:0]         sigmoid_lut [SIG_N];
    logic signed [VALUE_W-1:0] weights [FEATURES];
    logic [PROB_W-1:0]         threshold;
    longint                    dot_sum;
    u64_t                      tp, fp, fn, tn;
    score_t                    expected_scores [$];
    int                        errors;

    function new();
      build_lut();
      threshold = RESET_THRESHOLD;
      dot_sum   = 0;
      tp = 0; fp = 0; fn = 0; tn = 0;
      errors    = 0;
      foreach (weights[i]) weights[i] = '0;
    endfunction

    // e^(8*span/N) in Q24: Taylor series of e^(span/(2N)) in Q30, then squared four times
    function u64_t exp_q24(u64_t span);
      u64_t y, term, total, e;
      y     = (span << 29) / u64_t'(SIG_N);
      term  = u64_t'(1) << 30;
      total = term;
      for (int n = 1; n <= 12; n++) begin
        term  = ((term * y) >> 30) / u64_t'(n);
        total = total + term;
      end
      e = (total + 32) >> 6;
      for (int n = 0; n < 4; n++) begin
        e = (e * e + (u64_t'(1) << 23)) >> 24;
      end
      return e;
    endfunction

    function void build_lut();
      longint d;
      u64_t   e, den, num;
      for (int k = 0; k < SIG_N; k++) begin
        d   = 2 * k + 1 - SIG_N;
        e   = exp_q24(u64_t'(d < 0 ? -d : d));
        den = e + (u64_t'(1) << 24);
        num = (d >= 0) ? e * 65536 : (u64_t'(1) << 40);
        sigmoid_lut[k] = PROB_W'((num + den / 2) / den);
      end
    endfunction

    function u64_t bump(u64_t c);
      return (c >= CNT_FULL) ? CNT_FULL : c + 1;
    endfunction

    function void set_threshold(logic [PROB_W-1:0] v);
      threshold = v;
    endfunction

    function int pending();
      return expected_scores.size();
    endfunction

    // Apply one accepted request; an element marked last yields a score
    function void note_request(op_t op, logic [INDEX_W-1:0] idx,
                               logic signed [VALUE_W-1:0] val, bit last, bit label);
      longint            s;
      int                pos;
      logic [PROB_W-1:0] prob;
      bit                pred;
      score_t            want;
      case (op)
        OP_LOAD: begin
          if (idx < FEATURES) weights[idx] = val;
        end
        OP_CLEAR: begin
          tp = 0; fp = 0; fn = 0; tn = 0;
        end
        OP_FEATURE: begin
          if (idx < FEATURES) dot_sum = dot_sum + longint'(weights[idx]) * longint'(val);
          if (dot_sum > ACC_HI) dot_sum = ACC_HI;
          if (dot_sum < ACC_LO) dot_sum = ACC_LO;
          if (last) begin
            // clamp to [-8,8) and index the table
            s = dot_sum;
            if (s > SUM_HI) s = SUM_HI;
            if (s < SUM_LO) s = SUM_LO;
            pos = int'(((s - SUM_LO) * SIG_N) >>> 28);
            if (pos >= SIG_N) pos = SIG_N - 1;
            prob = sigmoid_lut[pos];
            pred = (prob >= threshold);
            if (label && pred)       tp = bump(tp);
            else if (!label && pred) fp = bump(fp);
            else if (label)          fn = bump(fn);
            else                     tn = bump(tn);
            dot_sum = 0;
            want.probability     = prob;
            want.predicted_class = pred;
            want.true_positives  = tp[31:0];
            want.false_positives = fp[31:0];
            want.false_negatives = fn[31:0];
            want.true_negatives  = tn[31:0];
            expected_scores.push_back(want);
          end
        end
        default: ;
      endcase
    endfunction

    task report(string what);
      $display("[%0t] score error: %s", $time, what);
      errors++;
    endtask

    // Compare one score against the oldest expectation, field by field
    task check_score(score_t got);
      score_t want;
      u64_t   got_f [6];
      u64_t   want_f [6];
      string  names [6];
      names = '{"probability", "predicted_class", "true_positives",
                "false_positives", "false_negatives", "true_negatives"};
      if (expected_scores.size() == 0) begin
        report("score with no example pending");
        return;
      end
      want   = expected_scores.pop_front();
      got_f  = '{got.probability, got.predicted_class, got.true_positives,
                 got.false_positives, got.false_negatives, got.true_negatives};
      want_f = '{want.probability, want.predicted_class, want.true_positives,
                 want.false_positives, want.false_negatives, want.true_negatives};
      foreach (names[i]) begin
        if (got_f[i] !== want_f[i])
          report($sformatf("%s got %0d, expected %0d", names[i], got_f[i], want_f[i]));
      end
    endtask
  endclass

  // --------------------------------------------------------------------------
  // Clock, reset, channels, DUT
  // --------------------------------------------------------------------------
  logic clk = 1'b0;
  logic rst_n;
  bit   steady;
  int   cycle_count;
  bit   loaded [FEATURES];
  int   loaded_list [$];

  confusion_scoreboard board = new();

  lrs_in_if  in_if ();
  lrs_out_if out_if ();
  lrs_cfg_if cfg_if ();

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  logistic_regression_scorer i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_if),
    .out_chan (out_if),
    .cfg_chan (cfg_if)
  );

  // Run limit
  initial cycle_count = 0;
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("logistic_regression_scorer: mismatch");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Result side: random stalls, check on each accepted score
  // --------------------------------------------------------------------------
  function automatic int idle_length();
    return ($urandom_range(0, 9) == 0) ? $urandom_range(8, 24) : $urandom_range(1, 3);
  endfunction

  initial begin : result_sink
    int stall_left;
    stall_left   = 0;
    out_if.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (stall_left > 0) begin
        out_if.ready = 1'b0;
        stall_left--;
      end else if (!steady && $urandom_range(0, 99) < 20) begin
        out_if.ready = 1'b0;
        stall_left   = idle_length() - 1;
      end else begin
        out_if.ready = 1'b1;
      end
    end
  end

  always @(posedge clk) begin : take_score
    score_t seen;
    if (rst_n && out_if.valid && out_if.ready) begin
      seen.probability     = out_if.probability;
      seen.predicted_class = out_if.predicted_class;
      seen.true_positives  = out_if.true_positives;
      seen.false_positives = out_if.false_positives;
      seen.false_negatives = out_if.false_negatives;
      seen.true_negatives  = out_if.true_negatives;
      board.check_score(seen);
    end
  end

  // --------------------------------------------------------------------------
  // Request side
  // --------------------------------------------------------------------------

  // One request: optional gap, present at falling edge, wait for accept
  task automatic send(op_t op, logic [INDEX_W-1:0] idx, logic signed [VALUE_W-1:0] val,
                      bit last, bit label);
    int gap;
    gap = (!steady && $urandom_range(0, 99) < 35) ? idle_length() : 0;
    @(negedge clk);
    if (gap > 0) begin
      in_if.valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_if.operation      = op;
    in_if.feature_index  = idx;
    in_if.element_value  = val;
    in_if.last_element   = last;
    in_if.observed_label = label;
    in_if.valid          = 1'b1;
    do @(posedge clk); while (!in_if.ready);
    board.note_request(op, idx, val, last, label);
  endtask

  task automatic load_weight(int idx, logic signed [VALUE_W-1:0] val);
    send(OP_LOAD, INDEX_W'(idx), val, 1'($urandom), 1'($urandom));
    if (!loaded[idx]) begin
      loaded[idx] = 1'b1;
      loaded_list.push_back(idx);
    end
  endtask

  task automatic send_feature(int idx, logic signed [VALUE_W-1:0] val, bit last, bit label);
    send(OP_FEATURE, INDEX_W'(idx), val, last, label);
  endtask

  // Q4.12 value: mostly within +-1.0, some within +-4.0, some full range
  function automatic logic signed [VALUE_W-1:0] rand_q412();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 70) return VALUE_W'(int'($urandom_range(0, 8192)) - 4096);
    if (pick < 90) return VALUE_W'(int'($urandom_range(0, 32768)) - 16384);
    return VALUE_W'($urandom);
  endfunction

  function automatic int pick_loaded();
    return loaded_list[$urandom_range(0, loaded_list.size() - 1)];
  endfunction

  // Drain: no request pending, all scores back, pipeline quiet
  task automatic settle();
    @(negedge clk);
    in_if.valid = 1'b0;
    while (board.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_threshold(logic [PROB_W-1:0] v);
    @(negedge clk);
    cfg_if.decision_threshold = v;
    cfg_if.valid              = 1'b1;
    do @(posedge clk); while (!cfg_if.ready);
    board.set_threshold(v);
    @(negedge clk);
    cfg_if.valid = 1'b0;
  endtask

  // Directed corners at the reset threshold
  task automatic directed_checks();
    load_weight(0, 16'sh7FFF);
    load_weight(1023, -16'sh8000);
    load_weight(5, 16'sd4096);
    load_weight(6, -16'sd8192);
    // zero sum sits in the middle of the table
    send_feature(5, 16'sd0, 1'b1, 1'b1);
    // large positive and negative sums clamp to the table ends
    send_feature(0, 16'sh7FFF, 1'b1, 1'b0);
    send_feature(1023, 16'sh7FFF, 1'b1, 1'b1);
    send_feature(1023, -16'sh8000, 1'b1, 1'b1);
    // reserved operation is dropped
    send(OP_NONE, 10'h3FF, -16'sd1, 1'b1, 1'b1);
    // clear in mid example: counters zero, partial sum survives
    send_feature(5, 16'sd4096, 1'b0, 1'b1);
    send(OP_CLEAR, 10'h155, 16'sh2AAA, 1'b0, 1'b0);
    send_feature(6, 16'sd1024, 1'b1, 1'b0);
    // exactly +8.0 clamps down, exactly -8.0 lands on entry zero
    load_weight(7, 16'sd8192);
    send_feature(7, 16'sd16384, 1'b1, 1'b1);
    send_feature(7, -16'sd16384, 1'b1, 1'b0);
    // smallest negative sum sits just below the midpoint
    load_weight(9, 16'sd1);
    send_feature(9, -16'sd1, 1'b1, 1'b1);
    // load directly followed by a read of the same weight
    load_weight(5, -16'sd4096);
    send_feature(5, 16'sd4096, 1'b1, 1'b0);
  endtask

  // Random traffic: mostly whole examples, with loads, clears and noise
  task automatic run_examples(int target);
    int done_items;
    int pick;
    int n_el;
    done_items = 0;
    while (done_items < target) begin
      pick = $urandom_range(0, 99);
      if (pick < 12) begin
        load_weight($urandom_range(0, FEATURES - 1), rand_q412());
        done_items++;
      end else if (pick < 15) begin
        send(OP_CLEAR, INDEX_W'($urandom), VALUE_W'($urandom), 1'($urandom), 1'($urandom));
        done_items++;
      end else if (pick < 18) begin
        send(OP_NONE, INDEX_W'($urandom), VALUE_W'($urandom), 1'($urandom), 1'($urandom));
      end else begin
        n_el = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 20) : $urandom_range(1, 6);
        for (int n = 1; n <= n_el; n++) begin
          if ($urandom_range(0, 39) == 0)
            send(OP_CLEAR, INDEX_W'($urandom), VALUE_W'($urandom), 1'($urandom),
                 1'($urandom));
          send_feature(pick_loaded(), rand_q412(), n == n_el, 1'($urandom));
        end
        done_items += n_el;
      end
    end
  endtask

  // --------------------------------------------------------------------------
  // Test sequence
  // --------------------------------------------------------------------------
  initial begin : stimulus
    logic [PROB_W-1:0] levels [7];
    steady                    = 1'b0;
    in_if.valid               = 1'b0;
    in_if.operation           = OP_NONE;
    in_if.feature_index       = '0;
    in_if.element_value       = '0;
    in_if.last_element        = 1'b0;
    in_if.observed_label      = 1'b0;
    cfg_if.valid              = 1'b0;
    cfg_if.decision_threshold = '0;
    rst_n                     = 1'b0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    directed_checks();

    // zero, one, exact one-point-oh, all ones, half, a table entry, reset value
    levels = '{17'd0, 17'd1, 17'd65536, 17'h1FFFF, 17'd32768,
               board.sigmoid_lut[$urandom_range(64, 191)], RESET_THRESHOLD};
    foreach (levels[p]) begin
      settle();
      write_threshold(levels[p]);
      steady = (p == 4);
      run_examples(PHASE_ITEMS);
    end

    steady = 1'b0;
    settle();
    if (board.errors == 0) begin
      $display("logistic_regression_scorer: match");
    end else begin
      $display("logistic_regression_scorer: mismatch");
    end
    $finish;
  end

endmodule

/* logistic_regression_scorer.f */
sv/lrs_pkg.sv
sv/lrs_in_if.sv
sv/lrs_out_if.sv
sv/lrs_cfg_if.sv
sv/lrs_front.sv
sv/lrs_queue.sv
sv/lrs_back.sv
sv/logistic_regression_scorer.sv
sim/tb_logistic_regression_scorer.sv
